FILE: rtl/close_peak_merger_core_defines.svh
// Assertion macros used by the close peak merger controller.
`ifndef CLOSE_PEAK_MERGER_CORE_DEFINES_SVH
`define CLOSE_PEAK_MERGER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define CPM_ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("cpm assertion failed");
`define CPM_ASSERT_NXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("cpm assertion failed");
`else
`define CPM_ASSERT_IMP(lbl, clk, rst, a, b)
`define CPM_ASSERT_NXT(lbl, clk, rst, a, b)
`endif
`endif

FILE: rtl/cpm_pkg.sv
// Types and constants of the close peak merger.
`default_nettype none
package cpm_pkg;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned MAX_CLUSTER = 65535;
  localparam int unsigned DIV_STEPS   = 80;
  localparam int unsigned MUL_STEPS   = 48;
  localparam int unsigned SQRT_STEPS  = 32;
  localparam int unsigned STEP_W      = 7;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_DECIDE, CMD_SQUARE, CMD_JOIN, CMD_START, CMD_CLOSE,
    CMD_PREP1, CMD_PREP2, CMD_DIV_STEP, CMD_MEAN_DONE, CMD_MUL_STEP,
    CMD_MULA_DONE, CMD_MULB_DONE, CMD_TERR_SINGLE, CMD_TERR_ZERO, CMD_TERR_SAT,
    CMD_TSQRT_INIT, CMD_SQRT_STEP, CMD_TSQRT_DONE, CMD_CSQRT_DONE, CMD_OUT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    logic    last;
  } cmd_t;

  typedef struct packed {
    logic joins;
    logic open;
    logic last;
    logic n_one;
    logic a_lt_b;
    logic q_ovf;
    logic out_busy;
  } sts_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECIDE, ST_SQUARE, ST_JOIN, ST_START, ST_PREP1, ST_PREP2,
    ST_MEAN_DIV, ST_MEAN_DONE, ST_TERR_ONE, ST_MUL_A, ST_MULA_DONE, ST_MUL_B,
    ST_MULB_DONE, ST_TERR_CHK, ST_TDIV, ST_TERR_PICK, ST_TSQRT, ST_TSQRT_DONE,
    ST_CSQRT, ST_CSQRT_DONE, ST_OUT, ST_CLOSE
  } state_t;
endpackage
`default_nettype wire

FILE: rtl/cpm_dp.sv
// Datapath: cluster accumulators, serial divider, multiplier and square root.
`default_nettype none
module cpm_dp #(
  parameter int unsigned MAX_CLUSTER = cpm_pkg::MAX_CLUSTER
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire cpm_pkg::cmd_t cmd,
  output cpm_pkg::sts_t     sts,
  input  wire logic         cfg_we,
  input  wire logic [15:0]  cfg_wdata,
  input  wire logic [31:0]  peak_time,
  input  wire logic [31:0]  peak_charge,
  input  wire logic [15:0]  peak_time_error,
  input  wire logic [15:0]  peak_charge_error,
  input  wire logic         last_peak,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [31:0]       merged_time,
  output logic [31:0]       merged_time_error,
  output logic [47:0]       merged_charge,
  output logic [23:0]       merged_charge_error,
  output logic              last_merged
);
  import cpm_pkg::*;

  logic [15:0] md;
  logic [31:0] t_in, q_in;
  logic [15:0] te_in, qe_in;
  logic        last_in;
  logic        open, join_r;
  logic [31:0] first_t, last_t;
  logic [CNT_W-1:0] count;
  logic [47:0] sum_off, sum_q, sum_qe;
  logic [63:0] sum_sq;
  logic [15:0] fte;
  logic [31:0] off, qe_sq;
  logic [63:0] off_sq;
  logic [31:0] nn;
  logic [47:0] d;
  logic [79:0] div_q;
  logic [47:0] div_r, div_d;
  logic [31:0] mean_t;
  logic [111:0] acc;
  logic [63:0] mcand;
  logic [47:0] mplier;
  logic [79:0] a_reg;
  logic        a_lt_b;
  logic [63:0] sq_x;
  logic [33:0] sq_rem;
  logic [31:0] sq_root;
  logic [31:0] terr;
  logic [23:0] cerr;

  logic [31:0] gap;
  logic        join_c;
  logic [48:0] r_sh;
  logic        div_ge;
  logic [35:0] s_sh, s_trial;
  logic        sq_ge;
  logic [64:0] sq_sum;

  always_comb begin
    gap = t_in - last_t;
    join_c = open && (md != 16'd0) && (t_in >= last_t) && (gap <= {16'd0, md}) &&
             (count < MAX_CLUSTER[CNT_W-1:0]);
    r_sh = {div_r, div_q[79]};
    div_ge = r_sh >= {1'b0, div_d};
    s_sh = {sq_rem, sq_x[63:62]};
    s_trial = {2'b00, sq_root, 2'b01};
    sq_ge = s_sh >= s_trial;
    sq_sum = {1'b0, sum_sq} + {1'b0, off_sq};
  end

  assign sts.joins    = join_r;
  assign sts.open     = open;
  assign sts.last     = last_in;
  assign sts.n_one    = count == {{(CNT_W-1){1'b0}}, 1'b1};
  assign sts.a_lt_b   = a_lt_b;
  assign sts.q_ovf    = div_q[79:64] != 16'd0;
  assign sts.out_busy = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      md <= 16'd0;
      open <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) md <= cfg_wdata;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (cmd.op)
        CMD_START: open <= 1'b1;
        CMD_CLOSE: open <= 1'b0;
        CMD_OUT:   out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_LOAD: begin
        t_in <= peak_time;
        q_in <= peak_charge;
        te_in <= peak_time_error;
        qe_in <= peak_charge_error;
        last_in <= last_peak;
      end
      CMD_DECIDE: begin
        join_r <= join_c;
        off <= t_in - first_t;
        qe_sq <= qe_in * qe_in;
      end
      CMD_SQUARE: off_sq <= off * off;
      CMD_JOIN: begin
        sum_off <= sum_off + {16'd0, off};
        sum_sq <= sq_sum[64] ? {64{1'b1}} : sq_sum[63:0];
        sum_q <= sum_q + {16'd0, q_in};
        sum_qe <= sum_qe + {16'd0, qe_sq};
        count <= count + 1'b1;
        last_t <= t_in;
      end
      CMD_START: begin
        first_t <= t_in;
        last_t <= t_in;
        count <= {{(CNT_W-1){1'b0}}, 1'b1};
        sum_off <= 48'd0;
        sum_sq <= 64'd0;
        sum_q <= {16'd0, q_in};
        sum_qe <= {16'd0, qe_sq};
        fte <= te_in;
      end
      CMD_PREP1: begin
        nn <= count * count;
        div_q <= {32'd0, sum_off};
        div_r <= 48'd0;
        div_d <= {32'd0, count};
      end
      CMD_PREP2: d <= nn * (count - 1'b1);
      CMD_DIV_STEP: begin
        div_r <= div_ge ? 48'(r_sh - {1'b0, div_d}) : r_sh[47:0];
        div_q <= {div_q[78:0], div_ge};
      end
      CMD_MEAN_DONE: begin
        mean_t <= first_t + div_q[31:0];
        acc <= 112'd0;
        mcand <= sum_sq;
        mplier <= {32'd0, count};
      end
      CMD_MUL_STEP: begin
        acc <= {acc[110:0], 1'b0} + (mplier[47] ? {48'd0, mcand} : 112'd0);
        mplier <= {mplier[46:0], 1'b0};
      end
      CMD_MULA_DONE: begin
        a_reg <= acc[79:0];
        acc <= 112'd0;
        mcand <= {16'd0, sum_off};
        mplier <= sum_off;
      end
      CMD_MULB_DONE: begin
        a_lt_b <= {16'd0, a_reg} < acc[95:0];
        div_q <= a_reg - acc[79:0];
        div_r <= 48'd0;
        div_d <= d;
      end
      CMD_TERR_SINGLE, CMD_TERR_ZERO, CMD_TERR_SAT, CMD_TSQRT_DONE: begin
        case (cmd.op)
          CMD_TERR_SINGLE: terr <= {16'd0, fte};
          CMD_TERR_ZERO:   terr <= 32'd0;
          CMD_TERR_SAT:    terr <= {32{1'b1}};
          default:         terr <= sq_root;
        endcase
        sq_x <= {16'd0, sum_qe};
        sq_rem <= 34'd0;
        sq_root <= 32'd0;
      end
      CMD_TSQRT_INIT: begin
        sq_x <= div_q[63:0];
        sq_rem <= 34'd0;
        sq_root <= 32'd0;
      end
      CMD_SQRT_STEP: begin
        sq_rem <= sq_ge ? 34'(s_sh - s_trial) : s_sh[33:0];
        sq_root <= {sq_root[30:0], sq_ge};
        sq_x <= {sq_x[61:0], 2'b00};
      end
      CMD_CSQRT_DONE: cerr <= sq_root[23:0];
      CMD_OUT: begin
        merged_time <= mean_t;
        merged_time_error <= terr;
        merged_charge <= sum_q;
        merged_charge_error <= cerr;
        last_merged <= cmd.last;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/cpm_ctrl.sv
// Controller: sequences cluster update and merged-peak computation.
`default_nettype none
`include "close_peak_merger_core_defines.svh"
module cpm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire cpm_pkg::sts_t sts,
  output cpm_pkg::cmd_t      cmd
);
  import cpm_pkg::*;

  state_t state, state_next;
  logic [STEP_W-1:0] cnt, cnt_next;
  logic final_r, final_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      final_r <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      final_r <= final_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    final_next = final_r;
    cmd.op = CMD_NONE;
    cmd.last = final_r;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op = CMD_LOAD;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.op = CMD_DECIDE;
        state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd.op = CMD_SQUARE;
        if (sts.joins) state_next = ST_JOIN;
        else if (sts.open) begin
          final_next = 1'b0;
          state_next = ST_PREP1;
        end else state_next = ST_START;
      end
      ST_JOIN, ST_START: begin
        cmd.op = (state == ST_JOIN) ? CMD_JOIN : CMD_START;
        final_next = 1'b1;
        state_next = sts.last ? ST_PREP1 : ST_IDLE;
      end
      ST_PREP1: begin
        cmd.op = CMD_PREP1;
        state_next = ST_PREP2;
      end
      ST_PREP2: begin
        cmd.op = CMD_PREP2;
        cnt_next = STEP_W'(DIV_STEPS - 1);
        state_next = ST_MEAN_DIV;
      end
      ST_MEAN_DIV, ST_TDIV: begin
        cmd.op = CMD_DIV_STEP;
        cnt_next = cnt - 1'b1;
        if (cnt == '0) state_next = (state == ST_MEAN_DIV) ? ST_MEAN_DONE : ST_TERR_PICK;
      end
      ST_MEAN_DONE: begin
        cmd.op = CMD_MEAN_DONE;
        cnt_next = STEP_W'(MUL_STEPS - 1);
        state_next = sts.n_one ? ST_TERR_ONE : ST_MUL_A;
      end
      ST_TERR_ONE: begin
        cmd.op = CMD_TERR_SINGLE;
        cnt_next = STEP_W'(SQRT_STEPS - 1);
        state_next = ST_CSQRT;
      end
      ST_MUL_A, ST_MUL_B: begin
        cmd.op = CMD_MUL_STEP;
        cnt_next = cnt - 1'b1;
        if (cnt == '0) state_next = (state == ST_MUL_A) ? ST_MULA_DONE : ST_MULB_DONE;
      end
      ST_MULA_DONE: begin
        cmd.op = CMD_MULA_DONE;
        cnt_next = STEP_W'(MUL_STEPS - 1);
        state_next = ST_MUL_B;
      end
      ST_MULB_DONE: begin
        cmd.op = CMD_MULB_DONE;
        state_next = ST_TERR_CHK;
      end
      ST_TERR_CHK: begin
        if (sts.a_lt_b) begin
          cmd.op = CMD_TERR_ZERO;
          cnt_next = STEP_W'(SQRT_STEPS - 1);
          state_next = ST_CSQRT;
        end else begin
          cnt_next = STEP_W'(DIV_STEPS - 1);
          state_next = ST_TDIV;
        end
      end
      ST_TERR_PICK: begin
        cnt_next = STEP_W'(SQRT_STEPS - 1);
        if (sts.q_ovf) begin
          cmd.op = CMD_TERR_SAT;
          state_next = ST_CSQRT;
        end else begin
          cmd.op = CMD_TSQRT_INIT;
          state_next = ST_TSQRT;
        end
      end
      ST_TSQRT, ST_CSQRT: begin
        cmd.op = CMD_SQRT_STEP;
        cnt_next = cnt - 1'b1;
        if (cnt == '0) state_next = (state == ST_TSQRT) ? ST_TSQRT_DONE : ST_CSQRT_DONE;
      end
      ST_TSQRT_DONE: begin
        cmd.op = CMD_TSQRT_DONE;
        cnt_next = STEP_W'(SQRT_STEPS - 1);
        state_next = ST_CSQRT;
      end
      ST_CSQRT_DONE: begin
        cmd.op = CMD_CSQRT_DONE;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!sts.out_busy) begin
          cmd.op = CMD_OUT;
          state_next = final_r ? ST_CLOSE : ST_START;
        end
      end
      ST_CLOSE: begin
        cmd.op = CMD_CLOSE;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `CPM_ASSERT_IMP(a_out_free, clk, rst, cmd.op == CMD_OUT, !sts.out_busy)
  `CPM_ASSERT_NXT(a_beat_decide, clk, rst, in_valid && !in_stall, state == ST_DECIDE)
  `CPM_ASSERT_IMP(a_join_open, clk, rst, state == ST_SQUARE && sts.joins, sts.open)
endmodule
`default_nettype wire

FILE: rtl/close_peak_merger_core.sv
// Top level of the close peak merger.
`default_nettype none
// Clusters time-sorted peaks and emits one merged peak per cluster. A peak
// beat is taken only while the block is idle. A peak that joins a cluster or
// opens one without closing another passes through the load, decide, square
// and join or start states. Before each merged peak is offered on the
// output, the bit-serial restoring divider runs 80 steps for the mean and 80
// for the variance, the shift-add multiplier 48 steps twice, and the
// digit-by-digit square root 32 steps for each of the two errors; a cluster
// of one peak skips the variance work. A peak that closes a cluster and is
// itself the last one causes two merged peaks back to back. The output
// register holds a finished beat until taken; the controller waits only if a
// second result is ready before the first has left.
module close_peak_merger_core #(
  parameter int unsigned MAX_CLUSTER = cpm_pkg::MAX_CLUSTER
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] peak_time,
  input  wire logic [31:0] peak_charge,
  input  wire logic [15:0] peak_time_error,
  input  wire logic [15:0] peak_charge_error,
  input  wire logic        last_peak,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      merged_time,
  output logic [31:0]      merged_time_error,
  output logic [47:0]      merged_charge,
  output logic [23:0]      merged_charge_error,
  output logic             last_merged
);
  import cpm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cpm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd)
  );

  cpm_dp #(.MAX_CLUSTER(MAX_CLUSTER)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .peak_time(peak_time), .peak_charge(peak_charge),
    .peak_time_error(peak_time_error), .peak_charge_error(peak_charge_error),
    .last_peak(last_peak), .out_valid(out_valid), .out_stall(out_stall),
    .merged_time(merged_time), .merged_time_error(merged_time_error),
    .merged_charge(merged_charge), .merged_charge_error(merged_charge_error),
    .last_merged(last_merged)
  );
endmodule
`default_nettype wire
